FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define AST_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define AST_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/vlfd_pkg.sv
// Types and constants of the varint length-prefixed frame decoder.
`default_nettype none

package vlfd_pkg;

  localparam int SEG_BITS = 7;
  localparam int CONT_BIT = 7;
  localparam int LEN_W = 31;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 31'd32768;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_PREFIX_LONG = 2'd1,
    ERR_OVER_MAX    = 2'd2,
    ERR_TRUNCATED   = 2'd3
  } err_code_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       empty_frame;
    err_code_t  error_code;
  } result_t;

endpackage

`default_nettype wire

FILE: design/vlfd_in_reg.sv
// Input register stage of the frame decoder.
`default_nettype none

module vlfd_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_valid,
  output logic                   s_ready,
  input  wire vlfd_pkg::in_item_t s_item,
  input  wire logic              take,
  output logic                   valid,
  output vlfd_pkg::in_item_t     item
);
  import vlfd_pkg::*;

  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

FILE: design/vlfd_decoder.sv
// Prefix and payload decode with frame state and the length limit register.
`default_nettype none

module vlfd_decoder #(
  parameter int MAX_PREFIX_BYTES = 5
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [vlfd_pkg::LEN_W-1:0] cfg_wdata,
  input  wire logic                      step,
  input  wire vlfd_pkg::in_item_t        item,
  output logic                           res_valid,
  output vlfd_pkg::result_t              res
);
  import vlfd_pkg::*;

  localparam int ACC_W = SEG_BITS * MAX_PREFIX_BYTES;
  localparam int CNT_W = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;
  localparam int CMP_W = (ACC_W > LEN_W) ? ACC_W : LEN_W;

  logic [LEN_W-1:0] max_len;
  logic             in_payload, in_payload_next;
  logic [ACC_W-1:0] length_accum, length_accum_next;
  logic [CNT_W-1:0] prefix_count, prefix_count_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic             at_first, at_first_next;

  logic [ACC_W-1:0] full;
  logic [CMP_W-1:0] full_ext;
  logic [CMP_W-1:0] max_ext;

  always_comb begin
    full = length_accum;
    for (int i = 0; i < MAX_PREFIX_BYTES; i++) begin
      if (prefix_count == CNT_W'(i)) begin
        full[i*SEG_BITS +: SEG_BITS] = full[i*SEG_BITS +: SEG_BITS] |
                                       item.in_byte[SEG_BITS-1:0];
      end
    end
    full_ext = CMP_W'(full);
    max_ext  = CMP_W'(max_len);
  end

  always_comb begin
    in_payload_next   = in_payload;
    length_accum_next = length_accum;
    prefix_count_next = prefix_count;
    bytes_left_next   = bytes_left;
    at_first_next     = at_first;
    res_valid         = 1'b0;
    res               = '0;
    res.error_code    = ERR_NONE;
    if (item.end_of_stream) begin
      in_payload_next   = 1'b0;
      length_accum_next = '0;
      prefix_count_next = '0;
      bytes_left_next   = '0;
      at_first_next     = 1'b1;
      if (in_payload || prefix_count != '0) begin
        res_valid      = 1'b1;
        res.error_code = ERR_TRUNCATED;
      end
    end else if (in_payload) begin
      res_valid          = 1'b1;
      res.payload_byte   = item.in_byte;
      res.first_of_frame = at_first;
      res.last_of_frame  = (bytes_left <= LEN_W'(1));
      at_first_next      = 1'b0;
      if (bytes_left != '0) begin
        bytes_left_next = bytes_left - LEN_W'(1);
      end
      if (bytes_left <= LEN_W'(1)) begin
        in_payload_next   = 1'b0;
        length_accum_next = '0;
        prefix_count_next = '0;
        bytes_left_next   = '0;
        at_first_next     = 1'b1;
      end
    end else if (item.in_byte[CONT_BIT]) begin
      if (prefix_count == CNT_W'(MAX_PREFIX_BYTES - 1)) begin
        length_accum_next = '0;
        prefix_count_next = '0;
        bytes_left_next   = '0;
        at_first_next     = 1'b1;
        res_valid         = 1'b1;
        res.error_code    = ERR_PREFIX_LONG;
      end else begin
        length_accum_next = full;
        prefix_count_next = prefix_count + 1'b1;
      end
    end else if (full_ext > max_ext) begin
      length_accum_next = '0;
      prefix_count_next = '0;
      bytes_left_next   = '0;
      at_first_next     = 1'b1;
      res_valid         = 1'b1;
      res.error_code    = ERR_OVER_MAX;
    end else if (full == '0) begin
      length_accum_next = '0;
      prefix_count_next = '0;
      bytes_left_next   = '0;
      at_first_next     = 1'b1;
      res_valid         = 1'b1;
      res.empty_frame   = 1'b1;
    end else begin
      in_payload_next   = 1'b1;
      length_accum_next = '0;
      prefix_count_next = '0;
      bytes_left_next   = full_ext[LEN_W-1:0];
      at_first_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len      <= MAX_LEN_RESET;
      in_payload   <= 1'b0;
      length_accum <= '0;
      prefix_count <= '0;
      bytes_left   <= '0;
      at_first     <= 1'b1;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (step) begin
        in_payload   <= in_payload_next;
        length_accum <= length_accum_next;
        prefix_count <= prefix_count_next;
        bytes_left   <= bytes_left_next;
        at_first     <= at_first_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/vlfd_out_reg.sv
// Output register stage of the frame decoder.
`default_nettype none

module vlfd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire vlfd_pkg::result_t res,
  output logic                   space,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output vlfd_pkg::result_t      m_res
);
  import vlfd_pkg::*;

  assign space = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res;
    end
  end

endmodule

`default_nettype wire

FILE: design/varint_length_frame_decoder.sv
// Top level of the varint length-prefixed frame decoder.
// Input stream: one received byte per request on s_axis; tuser set marks
// the end of the connection, which resets the frame state.
// Output stream: one request per payload byte, empty frame or error on
// m_axis; tlast marks the last byte of a frame, tuser carries first-byte,
// empty-frame and error code.
// The length limit is written via cfg_we / cfg_wdata, by the user only while idle;
// the block does not enforce it. Prefix bytes and a clean end of stream give no
// output request.
// Path: input register, then decode into the output register when it has space.
// Throughput: one byte per cycle when the output is not stalled; the decode of a byte
// is a single pass of prefix merge, a 35-bit length compare and a 31-bit decrement.
// Reset: synchronous; both stages empty, frame state cleared, length limit
// back to 32768.
// Stall: while m_axis_tready is low the result holds; the input register takes
// one byte only if empty, then s_axis_tready stays low until space frees.
`default_nettype none

module varint_length_frame_decoder #(
  parameter int MAX_PREFIX_BYTES = 5
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [vlfd_pkg::LEN_W-1:0] cfg_wdata,      // max_frame_length
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [7:0]                s_axis_tdata,   // in_byte
  input  wire logic [0:0]                s_axis_tuser,   // end_of_stream
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // payload_byte
  output logic                           m_axis_tlast,   // last_of_frame
  output logic [3:0]                     m_axis_tuser    // first_of_frame, empty_frame,
                                                         // error_code[1:0]
);
  import vlfd_pkg::*;

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     step;
  logic     space;
  logic     res_valid;
  result_t  res;
  result_t  m_res;

  assign s_item.in_byte       = s_axis_tdata;
  assign s_item.end_of_stream = s_axis_tuser[0];
  assign step = item_valid && space;

  vlfd_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .take    (step),
    .valid   (item_valid),
    .item    (item)
  );

  vlfd_decoder #(
    .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
  ) u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  vlfd_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (step && res_valid),
    .res     (res),
    .space   (space),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_res   (m_res)
  );

  assign m_axis_tdata = m_res.payload_byte;
  assign m_axis_tlast = m_res.last_of_frame;
  assign m_axis_tuser = {m_res.error_code, m_res.empty_frame, m_res.first_of_frame};

endmodule

`default_nettype wire

FILE: design/vlfd_checker.sv
// Port-level checker of the frame decoder and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module vlfd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic [3:0] m_axis_tuser
);

  `AST_CLK_RST(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output request changed")
  `AST_CLK_RST(a_marker_clean, clk, rst, m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[3:2] != 2'd0) |-> m_axis_tdata == 8'd0 && !m_axis_tlast && !m_axis_tuser[0], "marker or error request carries byte flags")
  `AST_CLK_RST(a_one_marker, clk, rst, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[3:2] == 2'd0, "empty frame flagged together with an error")
  `AST_CLK(a_reset_empty, clk, rst |=> s_axis_tready && !m_axis_tvalid, "stages not empty after reset")

endmodule

bind varint_length_frame_decoder vlfd_checker u_vlfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
